FILE: rtl/nec_ir_pulse_decoder_defines.svh
// Assertion macros for the NEC pulse decoder.
// They sample on clk and are disabled while rst_n is low.
`ifndef NEC_IR_PULSE_DECODER_DEFINES_SVH
`define NEC_IR_PULSE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

`define NEC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder assertion failed: same-cycle implication");

`define NEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder assertion failed: next-cycle implication");

`else

`define NEC_ASSERT_IMPLY(label, ante, cons)

`define NEC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/nec_ir_pkg.sv
`default_nettype none

package nec_ir_pkg;

    localparam int unsigned DUR_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CNT_W = 3;
    localparam int unsigned CFG_IDX_W = 3;

    typedef logic [DUR_W-1:0] dur_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_START   = 2'd1,
        ST_RECEIVE = 2'd2
    } state_t;

    typedef enum logic [1:0] {
        OP_FALL    = 2'd0,
        OP_RISE    = 2'd1,
        OP_TIMEOUT = 2'd2
    } op_t;

    localparam cfg_idx_t CFG_START_HIGH = 3'd0;
    localparam cfg_idx_t CFG_START_LOW  = 3'd1;
    localparam cfg_idx_t CFG_BIT_HIGH   = 3'd2;
    localparam cfg_idx_t CFG_ZERO_LOW   = 3'd3;
    localparam cfg_idx_t CFG_ONE_LOW    = 3'd4;
    localparam cfg_idx_t CFG_TOLERANCE  = 3'd5;

    localparam dur_t RST_START_HIGH = 16'd9000;
    localparam dur_t RST_START_LOW  = 16'd4500;
    localparam dur_t RST_BIT_HIGH   = 16'd560;
    localparam dur_t RST_ZERO_LOW   = 16'd560;
    localparam dur_t RST_ONE_LOW    = 16'd1690;
    localparam dur_t RST_TOLERANCE  = 16'd200;

    localparam cnt_t LAST_BIT = 3'd7;

endpackage

`default_nettype wire

FILE: rtl/nec_ir_pulse_decoder.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------
// input    | in_valid / in_ready    | op[1:0], pulse_us[15:0]
// result   | out_valid / out_ready  | data_byte[7:0]
// config   | cfg_valid / cfg_ready  | cfg_index[2:0], cfg_data[15:0]
//
// An accepted item sits in the input register while the tolerance compares and
// the state update run, and a finished byte is then registered in the result
// register; one item per cycle is taken unless a byte-completing item waits.
// An item that completes a byte waits in the input register while the result
// register is still full; other items pass regardless of the output side.
// Reset restores the default timings, idle state and an empty pipeline.
`default_nettype none

`include "nec_ir_pulse_decoder_defines.svh"

module nec_ir_pulse_decoder (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                op,
    input  nec_ir_pkg::dur_t          pulse_us,
    output logic                      out_valid,
    input  logic                      out_ready,
    output nec_ir_pkg::byte_t         data_byte,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  nec_ir_pkg::cfg_idx_t      cfg_index,
    input  nec_ir_pkg::dur_t          cfg_data
);

    import nec_ir_pkg::*;

    dur_t   start_high_reg;
    dur_t   start_low_reg;
    dur_t   bit_high_reg;
    dur_t   zero_low_reg;
    dur_t   one_low_reg;
    dur_t   tolerance_reg;

    logic       stage_valid_reg;
    logic [1:0] stage_op_reg;
    dur_t       stage_dur_reg;

    state_t state_reg;
    state_t state_next;
    byte_t  partial_reg;
    byte_t  partial_next;
    cnt_t   count_reg;
    cnt_t   count_next;

    logic   out_valid_reg;
    byte_t  out_byte_reg;

    logic   emit;
    byte_t  emit_byte;
    logic   fire;
    logic   match_start_high;
    logic   match_start_low;
    logic   match_bit_high;
    logic   match_zero;
    logic   match_one;
    byte_t  shifted;

    function automatic logic near(input dur_t dur, input dur_t expect_us, input dur_t tol);
        dur_t diff;
        diff = (dur > expect_us) ? (dur - expect_us) : (expect_us - dur);
        return diff < tol;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_high_reg <= RST_START_HIGH;
            start_low_reg  <= RST_START_LOW;
            bit_high_reg   <= RST_BIT_HIGH;
            zero_low_reg   <= RST_ZERO_LOW;
            one_low_reg    <= RST_ONE_LOW;
            tolerance_reg  <= RST_TOLERANCE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_START_HIGH: start_high_reg <= cfg_data;
                CFG_START_LOW:  start_low_reg  <= cfg_data;
                CFG_BIT_HIGH:   bit_high_reg   <= cfg_data;
                CFG_ZERO_LOW:   zero_low_reg   <= cfg_data;
                CFG_ONE_LOW:    one_low_reg    <= cfg_data;
                CFG_TOLERANCE:  tolerance_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign match_start_high = near(stage_dur_reg, start_high_reg, tolerance_reg);
    assign match_start_low  = near(stage_dur_reg, start_low_reg, tolerance_reg);
    assign match_bit_high   = near(stage_dur_reg, bit_high_reg, tolerance_reg);
    assign match_zero       = near(stage_dur_reg, zero_low_reg, tolerance_reg);
    assign match_one        = near(stage_dur_reg, one_low_reg, tolerance_reg);

    // Zero is checked first, so a one is only shifted in when zero misses.
    // The received bit lands at position 7 - count, which is ~count.
    always_comb
    begin
        shifted = partial_reg;
        shifted[~count_reg] = !match_zero;
    end

    always_comb
    begin
        state_next   = state_reg;
        partial_next = partial_reg;
        count_next   = count_reg;
        emit         = 1'b0;
        emit_byte    = shifted;
        case (state_reg)
            ST_START:
            begin
                case (stage_op_reg)
                    OP_FALL:
                    begin
                        if (!match_start_high)
                            state_next = ST_IDLE;
                    end
                    OP_RISE:
                    begin
                        if (match_start_low)
                        begin
                            partial_next = '0;
                            count_next   = '0;
                            state_next   = ST_RECEIVE;
                        end
                        else
                            state_next = ST_IDLE;
                    end
                    default: ;
                endcase
            end
            ST_RECEIVE:
            begin
                case (stage_op_reg)
                    OP_FALL:
                    begin
                        if (!match_bit_high)
                            state_next = ST_IDLE;
                    end
                    OP_RISE:
                    begin
                        if (match_zero || match_one)
                        begin
                            if (count_reg == LAST_BIT)
                            begin
                                emit         = 1'b1;
                                partial_next = '0;
                                count_next   = '0;
                            end
                            else
                            begin
                                partial_next = shifted;
                                count_next   = count_reg + cnt_t'(1);
                            end
                        end
                        else
                            state_next = ST_IDLE;
                    end
                    OP_TIMEOUT: state_next = ST_IDLE;
                    default: ;
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
                if (stage_op_reg == OP_RISE)
                    state_next = ST_START;
            end
        endcase
    end

    // An item that produces no byte never waits on the result register.
    assign fire     = stage_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (in_ready)
            stage_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_op_reg  <= op;
            stage_dur_reg <= pulse_us;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            partial_reg <= '0;
            count_reg   <= '0;
        end
        else if (fire)
        begin
            state_reg   <= state_next;
            partial_reg <= partial_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
            out_byte_reg <= emit_byte;
    end

    assign out_valid = out_valid_reg;
    assign data_byte = out_byte_reg;

    `NEC_ASSERT_IMPLY(a_byte_only_from_receive, $rose(out_valid_reg), $past(state_reg == ST_RECEIVE))
    `NEC_ASSERT_NEXT(a_clear_after_byte, fire && emit, (count_reg == '0) && (partial_reg == '0))
    `NEC_ASSERT_IMPLY(a_idle_exits_to_start, fire && (state_reg == ST_IDLE) && (state_next != ST_IDLE), state_next == ST_START)

endmodule

`default_nettype wire

FILE: tb/nec_ir_pulse_decoder_tb.sv
`default_nettype none

module nec_ir_pulse_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nec_ir_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_AFTER_ITEMS = 400;
    localparam int HOLD_CYCLES = 600;

    typedef struct {
        logic [1:0] code;
        dur_t       dur;
    } edge_item_t;

    typedef struct {
        state_t fsm;
        byte_t  shreg;
        cnt_t   nbits;
    } decode_state_t;

    typedef struct {
        dur_t start_high;
        dur_t start_low;
        dur_t bit_high;
        dur_t zero_low;
        dur_t one_low;
        dur_t tol;
    } pulse_timing_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    logic [1:0] op = 2'd0;
    dur_t     pulse_us = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    byte_t    data_byte;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    cfg_idx_t cfg_index = '0;
    dur_t     cfg_data = '0;

    edge_item_t    pending_edges[$];
    byte_t         expected_bytes[$];
    pulse_timing_t timing;
    decode_state_t gen_st = '{ST_IDLE, 8'h00, 3'd0};
    decode_state_t live_st = '{ST_IDLE, 8'h00, 3'd0};

    int mismatches = 0;
    int accepted = 0;
    int queued = 0;
    int send_gap = 0;
    int send_quiet = 0;
    int recv_stall = 0;
    int recv_quiet = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int cycle_cnt = 0;

    nec_ir_pulse_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .pulse_us   (pulse_us),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_byte  (data_byte),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit within_tol(dur_t d, dur_t target, dur_t tol);
        dur_t diff;
        diff = (d > target) ? d - target : target - d;
        return diff < tol;
    endfunction

    // Advances one decoder state by one edge; returns 1 when a byte completes.
    function automatic bit decode_edge(ref decode_state_t s, input pulse_timing_t t,
                                       input logic [1:0] code, input dur_t d,
                                       output byte_t done_byte);
        bit got_bit;
        bit bit_val;
        got_bit = 1'b0;
        bit_val = 1'b0;
        done_byte = '0;
        case (s.fsm)
            ST_START:
            begin
                if (code == OP_FALL) begin
                    if (!within_tol(d, t.start_high, t.tol))
                        s.fsm = ST_IDLE;
                end else if (code == OP_RISE) begin
                    if (within_tol(d, t.start_low, t.tol)) begin
                        s.shreg = '0;
                        s.nbits = '0;
                        s.fsm = ST_RECEIVE;
                    end else begin
                        s.fsm = ST_IDLE;
                    end
                end
            end
            ST_RECEIVE:
            begin
                if (code == OP_FALL) begin
                    if (!within_tol(d, t.bit_high, t.tol))
                        s.fsm = ST_IDLE;
                end else if (code == OP_RISE) begin
                    // A space that fits both windows decodes as a zero.
                    if (within_tol(d, t.zero_low, t.tol)) begin
                        got_bit = 1'b1;
                    end else if (within_tol(d, t.one_low, t.tol)) begin
                        got_bit = 1'b1;
                        bit_val = 1'b1;
                    end else begin
                        s.fsm = ST_IDLE;
                    end
                end else if (code == OP_TIMEOUT) begin
                    s.fsm = ST_IDLE;
                end
            end
            default:
            begin
                s.fsm = (code == OP_RISE) ? ST_START : ST_IDLE;
            end
        endcase
        if (got_bit) begin
            s.shreg = s.shreg | (byte_t'(bit_val) << (LAST_BIT - s.nbits));
            if (s.nbits == LAST_BIT) begin
                done_byte = s.shreg;
                s.shreg = '0;
                s.nbits = '0;
                return 1'b1;
            end
            s.nbits = s.nbits + 3'd1;
        end
        return 1'b0;
    endfunction

    function automatic dur_t any_dur();
        return dur_t'($urandom_range(0, 16'hFFFF));
    endfunction

    // Mostly inside the window, often right on its edges, rarely just outside.
    function automatic dur_t pick_near(dur_t target);
        int tol;
        int off;
        int r;
        int v;
        tol = int'(timing.tol);
        r = $urandom_range(0, 99);
        if (tol == 0)
            off = 0;
        else if (r < 8)
            off = tol - 1;
        else if (r < 16)
            off = 1 - tol;
        else if (r == 16)
            off = tol;
        else if (r == 17)
            off = -tol;
        else
            off = int'($urandom_range(0, 2 * tol - 2)) - (tol - 1);
        v = int'(target) + off;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return dur_t'(v);
    endfunction

    task automatic push_edge(logic [1:0] code, dur_t d);
        edge_item_t it;
        byte_t unused_byte;
        it.code = code;
        it.dur = d;
        void'(decode_edge(gen_st, timing, code, d, unused_byte));
        pending_edges.push_back(it);
        queued++;
    endtask

    // One remote frame: start burst and space, a run of bits, a trailing burst.
    task automatic push_frame();
        int nbits;
        int r;
        logic [1:0] code;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            repeat ($urandom_range(1, 4)) begin
                code = 2'($urandom_range(0, 3));
                push_edge(code, any_dur());
            end
        end
        if (gen_st.fsm == ST_RECEIVE)
            push_edge(OP_TIMEOUT, any_dur());
        if (gen_st.fsm == ST_IDLE)
            push_edge(OP_RISE, any_dur());
        push_edge(OP_FALL, pick_near(timing.start_high));
        push_edge(OP_RISE, pick_near(timing.start_low));
        r = $urandom_range(0, 9);
        nbits = (r < 3) ? 8 : (r < 5) ? 16 : (r < 8) ? 32 : $urandom_range(1, 40);
        repeat (nbits) begin
            push_edge(OP_FALL, pick_near(timing.bit_high));
            if ($urandom_range(0, 1))
                push_edge(OP_RISE, pick_near(timing.one_low));
            else
                push_edge(OP_RISE, pick_near(timing.zero_low));
            if ($urandom_range(0, 99) == 0) begin
                code = 2'($urandom_range(0, 3));
                push_edge(code, any_dur());
            end
        end
        push_edge(OP_FALL, pick_near(timing.bit_high));
        push_edge(OP_TIMEOUT, any_dur());
    endtask

    task automatic wait_drained();
        while (pending_edges.size() != 0 || in_valid || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, dur_t v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_START_HIGH: timing.start_high = v;
            CFG_START_LOW:  timing.start_low = v;
            CFG_BIT_HIGH:   timing.bit_high = v;
            CFG_ZERO_LOW:   timing.zero_low = v;
            CFG_ONE_LOW:    timing.one_low = v;
            default:        timing.tol = v;
        endcase
    endtask

    task automatic program_timing(dur_t sh, dur_t sl, dur_t bh, dur_t zl, dur_t ol, dur_t tol);
        write_reg(CFG_START_HIGH, sh);
        write_reg(CFG_START_LOW, sl);
        write_reg(CFG_BIT_HIGH, bh);
        write_reg(CFG_ZERO_LOW, zl);
        write_reg(CFG_ONE_LOW, ol);
        write_reg(CFG_TOLERANCE, tol);
    endtask

    task automatic run_random(int count);
        int stop_at;
        stop_at = queued + count;
        while (queued < stop_at)
            push_frame();
    endtask

    task automatic report_mismatch(string what, byte_t got, byte_t want);
        $display("ERROR at %0t: %s: got %02h, want %02h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n) begin : drive_edges
        edge_item_t nxt;
        byte_t done_byte;
        int r;
        if (!rst_n) begin
            in_valid <= 1'b0;
            accepted <= 0;
        end else begin
            if (in_valid && in_ready) begin
                if (decode_edge(live_st, timing, op, pulse_us, done_byte))
                    expected_bytes.push_back(done_byte);
                accepted <= accepted + 1;
            end
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_edges.size() != 0) begin
                    nxt = pending_edges.pop_front();
                    in_valid <= 1'b1;
                    op <= nxt.code;
                    pulse_us <= nxt.dur;
                    if (send_quiet > 0) begin
                        send_quiet--;
                    end else begin
                        r = $urandom_range(0, 99);
                        if (r < 2)
                            send_quiet = $urandom_range(40, 120);
                        else if (r < 7)
                            send_gap = $urandom_range(10, 40);
                        else if (r < 30)
                            send_gap = $urandom_range(1, 3);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Once enough items have gone in, the receiver stops taking bytes for a
    // long stretch so that the result side fills and the input side stalls.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && accepted >= HOLD_AFTER_ITEMS) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n) begin : check_bytes
        byte_t want;
        int r;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("byte with none expected", data_byte, 8'h00);
                end else begin
                    want = expected_bytes.pop_front();
                    if (data_byte !== want)
                        report_mismatch("data_byte", data_byte, want);
                end
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (recv_quiet > 0) begin
                    recv_quiet--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 1)
                        recv_quiet = $urandom_range(100, 300);
                    else if (r < 4)
                        recv_stall = $urandom_range(20, 60);
                    else if (r < 20)
                        recv_stall = $urandom_range(1, 3);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        byte_t pattern;
        dur_t zl;
        timing = '{RST_START_HIGH, RST_START_LOW, RST_BIT_HIGH,
                   RST_ZERO_LOW, RST_ONE_LOW, RST_TOLERANCE};

        // Directed frame at the reset timings: ignored codes in every state,
        // windows hit on their edges, then one full byte.
        push_edge(OP_UNUSED, 16'hFFFF);
        push_edge(OP_TIMEOUT, 16'h0000);
        push_edge(OP_RISE, 16'hFFFF);
        push_edge(OP_TIMEOUT, 16'd123);
        push_edge(OP_UNUSED, 16'h0000);
        push_edge(OP_FALL, RST_START_HIGH + 16'd199);
        push_edge(OP_RISE, RST_START_LOW - 16'd199);
        pattern = 8'hA5;
        for (int i = 7; i >= 0; i--) begin
            push_edge(OP_FALL, (i % 2 == 0) ? RST_BIT_HIGH + 16'd199 : RST_BIT_HIGH - 16'd199);
            push_edge(OP_RISE, pattern[i] ? RST_ONE_LOW - 16'd199 : RST_ZERO_LOW + 16'd199);
            if (i == 4)
                push_edge(OP_UNUSED, 16'h5A5A);
        end
        push_edge(OP_TIMEOUT, 16'h5A5A);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        zl = dur_t'($urandom_range(200, 1500));
        program_timing(dur_t'($urandom_range(2000, 20000)), dur_t'($urandom_range(1000, 10000)),
                       dur_t'($urandom_range(200, 1500)), zl,
                       zl + dur_t'($urandom_range(500, 2000)), dur_t'($urandom_range(50, 250)));
        run_random(450);
        wait_drained();

        // With no tolerance nothing can match, so no byte is ever produced.
        program_timing(RST_START_HIGH, RST_START_LOW, RST_BIT_HIGH,
                       RST_ZERO_LOW, RST_ONE_LOW, 16'd0);
        run_random(150);
        wait_drained();

        program_timing(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'd1);
        run_random(350);
        wait_drained();

        program_timing(any_dur(), any_dur(), any_dur(), 16'h0000, 16'hFFFF, 16'hFFFF);
        run_random(350);
        wait_drained();

        // Overlapping zero and one windows.
        program_timing(16'd9000, 16'd4500, 16'd560, 16'd1000, 16'd1100, 16'd200);
        run_random(350);
        wait_drained();

        program_timing(RST_START_HIGH, RST_START_LOW, RST_BIT_HIGH,
                       RST_ZERO_LOW, RST_ONE_LOW, RST_TOLERANCE);
        run_random(350);
        wait_drained();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
